[src/bcf_pkg.sv]
// Shared types and constants of the banded Cholesky factor block.
`timescale 1ns / 1ps
package bcf_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = 6;
  localparam int ORDER_W    = 16;
  localparam int BAND_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_LOWER   = 2'd1;

  typedef enum logic [3:0] {
    ST_RECV,
    ST_ROW,
    ST_MACQ,
    ST_MUL,
    ST_ACC,
    ST_SUB,
    ST_PIV,
    ST_SQRT,
    ST_DIV,
    ST_DIVW,
    ST_EMIT,
    ST_ERR,
    ST_NEXT
  } bcf_state_e;

  typedef struct packed {
    logic             buf_wr;
    logic             acc_clr;
    logic             rd_en;
    logic             mul_en;
    logic             acc_en;
    logic             sub_en;
    logic             sqrt_start;
    logic             div_start;
    logic             emit;
    logic             err;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] gap;
    logic [IDX_W-1:0] slot;
  } bcf_cmd_t;

  typedef struct packed {
    logic v_pos;
    logic sqrt_done;
    logic div_done;
    logic out_free;
  } bcf_status_t;

endpackage

[src/bcf_elem_if.sv]
// Input channel carrying one lower band element per transfer.
`timescale 1ns / 1ps
interface bcf_elem_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

[src/bcf_factor_if.sv]
// Output channel carrying one factor element per transfer.
`timescale 1ns / 1ps
interface bcf_factor_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] factor_value;
  logic                         column_last;
  logic                         not_pos_def;

  modport source (output valid, output factor_value, output column_last,
                  output not_pos_def, input ready);
  modport sink   (input valid, input factor_value, input column_last,
                  input not_pos_def, output ready);
endinterface

[src/bcf_sqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module bcf_sqrt #(
  parameter int IN_W = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [IN_W-1:0]   radicand_i,
  output logic              done_o,
  output logic [IN_W/2-1:0] root_o
);
  localparam int HW = IN_W / 2;
  localparam int RW = HW + 2;
  localparam int CW = $clog2(HW + 1);

  logic [IN_W-1:0] x_q;
  logic [RW-1:0]   rem_q;
  logic [HW-1:0]   root_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [RW-1:0] rem_sh_w;
  logic [RW-1:0] trial_w;
  logic          ge_w;

  assign rem_sh_w = {rem_q[RW-3:0], x_q[IN_W-1 -: 2]};
  assign trial_w  = {root_q, 2'b01};
  assign ge_w     = rem_sh_w >= trial_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(HW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[IN_W-3:0], 2'b00};
      rem_q  <= ge_w ? (rem_sh_w - trial_w) : rem_sh_w;
      root_q <= {root_q[HW-2:0], ge_w};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[src/bcf_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bcf_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] numer_i,
  input  logic [DEN_W-1:0] denom_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0] rem_sh_w;
  logic [DEN_W:0] diff_w;
  logic           ge_w;

  assign rem_sh_w = {rem_q, num_q[NUM_W-1]};
  assign diff_w   = rem_sh_w - {1'b0, den_q};
  assign ge_w     = rem_sh_w >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= numer_i;
      den_q <= denom_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], ge_w};
      rem_q <= ge_w ? diff_w[DEN_W-1:0] : rem_sh_w[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

[src/bcf_dpath.sv]
// Datapath: column buffer, factor window memory, MAC, root and divide units.
`timescale 1ns / 1ps
module bcf_dpath #(
  parameter int MAX_BAND   = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bcf_pkg::bcf_cmd_t            cmd_i,
  output bcf_pkg::bcf_status_t         status_o,
  input  logic signed [DATA_WIDTH-1:0] in_data_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic signed [DATA_WIDTH-1:0] out_value_o,
  output logic                         out_last_o,
  output logic                         out_npd_o
);
  import bcf_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int DEPTH = MAX_BAND * (MAX_BAND + 1);
  localparam int WA    = $clog2(DEPTH);
  localparam int BUF_N = MAX_BAND + 1;
  localparam int BA    = $clog2(BUF_N);
  localparam int PW    = 2 * DW;
  localparam int ACW   = PW - FRAC_BITS + $clog2(MAX_BAND) + 1;
  localparam int DFW   = ACW + 1;
  localparam int SW    = DW + FRAC_BITS + (DW % 2);
  localparam int RTW   = SW / 2;
  localparam int NW    = DW + FRAC_BITS;

  localparam logic signed [DW-1:0] SAT_HI = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_LO = {1'b1, {(DW-1){1'b0}}};
  localparam logic [NW-1:0]        Q_HI   = NW'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [PW-1:0] HALF   =
    {{(PW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  logic signed [DW-1:0]  win_mem [DEPTH];
  logic signed [DW-1:0]  colbuf_q [BUF_N];
  logic signed [DW-1:0]  rda_q, rdb_q;
  logic signed [PW-1:0]  prod_q;
  logic signed [ACW-1:0] acc_q;
  logic signed [DW-1:0]  v_q;

  logic                  out_valid_q;
  logic signed [DW-1:0]  out_value_q;
  logic                  out_last_q;
  logic                  out_npd_q;

  logic [WA-1:0]         wr_addr_w, rda_addr_w, rdb_addr_w;
  logic signed [PW-1:0]  prod_w, rnd_w, rnd_sh_w;
  logic signed [DFW-1:0] diff_w;
  logic signed [DW-1:0]  v_sat_w;
  logic [DW-1:0]         vmag_w;
  logic                  sqrt_done_w, div_done_w;
  logic [RTW-1:0]        root_w;
  logic [NW-1:0]         quot_w;
  logic signed [DW-1:0]  piv_l_w, div_l_w, l_w;
  logic                  out_free_w;

  assign wr_addr_w  = WA'(int'(cmd_i.slot) * (MAX_BAND + 1) + int'(cmd_i.row));
  assign rda_addr_w = WA'(int'(cmd_i.slot) * (MAX_BAND + 1)
                          + int'(cmd_i.row) + int'(cmd_i.gap));
  assign rdb_addr_w = WA'(int'(cmd_i.slot) * (MAX_BAND + 1) + int'(cmd_i.gap));

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      win_mem[wr_addr_w] <= l_w;
    end
    if (cmd_i.rd_en) begin
      rda_q <= win_mem[rda_addr_w];
      rdb_q <= win_mem[rdb_addr_w];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.buf_wr) begin
      colbuf_q[cmd_i.row[BA-1:0]] <= in_data_i;
    end
  end

  // Exact product, rounded to Q16.16 by adding one half and flooring.
  assign prod_w   = rda_q * rdb_q;
  assign rnd_w    = prod_q + HALF;
  assign rnd_sh_w = rnd_w >>> FRAC_BITS;

  assign diff_w = DFW'(colbuf_q[cmd_i.row[BA-1:0]]) - DFW'(acc_q);

  always_comb begin
    if (diff_w > DFW'(SAT_HI)) begin
      v_sat_w = SAT_HI;
    end else if (diff_w < DFW'(SAT_LO)) begin
      v_sat_w = SAT_LO;
    end else begin
      v_sat_w = diff_w[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_w;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + ACW'(rnd_sh_w);
    end
    if (cmd_i.sub_en) begin
      v_q <= v_sat_w;
    end
  end

  assign vmag_w = v_q[DW-1] ? DW'(-v_q) : DW'(v_q);

  bcf_sqrt #(
    .IN_W (SW)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (SW'({v_q, {FRAC_BITS{1'b0}}})),
    .done_o     (sqrt_done_w),
    .root_o     (root_w)
  );

  bcf_div #(
    .NUM_W (NW),
    .DEN_W (RTW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .numer_i ({vmag_w, {FRAC_BITS{1'b0}}}),
    .denom_i (root_w),
    .done_o  (div_done_w),
    .quot_o  (quot_w)
  );

  always_comb begin
    piv_l_w = (NW'(root_w) > Q_HI) ? SAT_HI : DW'(root_w);
    if (quot_w > Q_HI) begin
      div_l_w = v_q[DW-1] ? SAT_LO : SAT_HI;
    end else begin
      div_l_w = v_q[DW-1] ? -quot_w[DW-1:0] : quot_w[DW-1:0];
    end
    l_w = (cmd_i.row == '0) ? piv_l_w : div_l_w;
  end

  assign out_free_w = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.err) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit || cmd_i.err) begin
      out_value_q <= cmd_i.err ? '0 : l_w;
      out_last_q  <= cmd_i.err ? 1'b1 : cmd_i.last;
      out_npd_q   <= cmd_i.err;
    end
  end

  assign status_o.v_pos     = v_q > 0;
  assign status_o.sqrt_done = sqrt_done_w;
  assign status_o.div_done  = div_done_w;
  assign status_o.out_free  = out_free_w;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;
  assign out_npd_o   = out_npd_q;

endmodule

[src/bcf_ctrl.sv]
// Controller: register file, column bookkeeping and sequencing state machine.
`timescale 1ns / 1ps
module bcf_ctrl #(
  parameter int MAX_BAND = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bcf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bcf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  bcf_pkg::bcf_status_t               status_i,
  output bcf_pkg::bcf_cmd_t                  cmd_o
);
  import bcf_pkg::*;

  localparam logic [IDX_W-1:0] MB = IDX_W'(MAX_BAND);

  bcf_state_e           state_q, state_d;
  logic [ORDER_W-1:0]   order_q;
  logic [BAND_W-1:0]    band_q;
  logic [ORDER_W-1:0]   col_q, col_d;
  logic [IDX_W-1:0]     slot_q, slot_d;
  logic [IDX_W-1:0]     row_q, row_d;
  logic [IDX_W-1:0]     r_q, r_d;
  logic [IDX_W-1:0]     d_q, d_d;
  logic                 failed_q, failed_d;

  logic [ORDER_W-1:0]   n_w, rem_w;
  logic [IDX_W-1:0]     b_w, len_w, dmax_w, kslot_w;
  logic                 last_col_w, row_last_w, r_last_w, fits_w, adv_w, cfg_hit_w;

  assign n_w    = (order_q == '0) ? ORDER_W'(1) : order_q;
  assign b_w    = (IDX_W'(band_q) > MB) ? MB : IDX_W'(band_q);
  assign rem_w  = n_w - ORDER_W'(1) - col_q;
  assign len_w  = ((rem_w < ORDER_W'(b_w)) ? rem_w[IDX_W-1:0] : b_w) + IDX_W'(1);
  assign dmax_w = (col_q < ORDER_W'(b_w)) ? col_q[IDX_W-1:0] : b_w;
  assign kslot_w = (slot_q >= d_q) ? (slot_q - d_q) : (slot_q + MB - d_q);

  assign last_col_w = (col_q == n_w - ORDER_W'(1));
  assign row_last_w = (row_q + IDX_W'(1) >= len_w);
  assign r_last_w   = (r_q + IDX_W'(1) == len_w);
  assign fits_w     = ({1'b0, r_q} + {1'b0, d_q}) <= {1'b0, b_w};
  assign cfg_hit_w  = cfg_we_i
                      && (cfg_index_i == REG_MATRIX_ORDER || cfg_index_i == REG_BAND_LOWER);

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_W'(1);
      band_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MATRIX_ORDER: order_q <= cfg_data_i[ORDER_W-1:0];
        REG_BAND_LOWER:   band_q  <= cfg_data_i[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RECV: if (in_valid_i && row_last_w && !failed_q) state_d = ST_ROW;
      ST_ROW:  state_d = ST_MACQ;
      ST_MACQ: begin
        if (d_q == '0) begin
          state_d = ST_SUB;
        end else if (fits_w) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = ST_MACQ;
      ST_SUB:  state_d = (r_q == '0) ? ST_PIV : ST_DIV;
      ST_PIV:  state_d = status_i.v_pos ? ST_SQRT : ST_ERR;
      ST_SQRT: if (status_i.sqrt_done) state_d = ST_EMIT;
      ST_DIV:  state_d = ST_DIVW;
      ST_DIVW: if (status_i.div_done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = r_last_w ? ST_NEXT : ST_ROW;
        end
      end
      ST_ERR:  if (status_i.out_free) state_d = ST_NEXT;
      ST_NEXT: state_d = ST_RECV;
      default: state_d = ST_RECV;
    endcase
  end

  // Counters and column bookkeeping
  always_comb begin
    col_d    = col_q;
    slot_d   = slot_q;
    row_d    = row_q;
    r_d      = r_q;
    d_d      = d_q;
    failed_d = failed_q;
    adv_w    = 1'b0;
    case (state_q)
      ST_RECV: begin
        if (in_valid_i) begin
          if (row_last_w) begin
            row_d = '0;
            r_d   = '0;
            adv_w = failed_q;
          end else begin
            row_d = row_q + IDX_W'(1);
          end
        end
      end
      ST_ROW:  d_d = dmax_w;
      ST_MACQ: if (d_q != '0 && !fits_w) d_d = d_q - IDX_W'(1);
      ST_ACC:  d_d = d_q - IDX_W'(1);
      ST_EMIT: if (status_i.out_free && !r_last_w) r_d = r_q + IDX_W'(1);
      ST_ERR:  if (status_i.out_free) failed_d = 1'b1;
      ST_NEXT: adv_w = 1'b1;
      default: ;
    endcase
    if (adv_w) begin
      if (last_col_w) begin
        col_d    = '0;
        slot_d   = '0;
        failed_d = 1'b0;
      end else begin
        col_d  = col_q + ORDER_W'(1);
        slot_d = (slot_q == MB - IDX_W'(1)) ? '0 : slot_q + IDX_W'(1);
      end
    end
    if (cfg_hit_w) begin
      col_d    = '0;
      slot_d   = '0;
      row_d    = '0;
      failed_d = 1'b0;
    end
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cmd_o.row  = r_q;
    cmd_o.gap  = d_q;
    cmd_o.slot = kslot_w;
    cmd_o.last = r_last_w;
    unique case (state_q)
      ST_RECV: begin
        in_ready_o    = 1'b1;
        cmd_o.row     = row_q;
        cmd_o.buf_wr  = in_valid_i && !failed_q;
      end
      ST_ROW:  cmd_o.acc_clr = 1'b1;
      ST_MACQ: cmd_o.rd_en = (d_q != '0) && fits_w;
      ST_MUL:  cmd_o.mul_en = 1'b1;
      ST_ACC:  cmd_o.acc_en = 1'b1;
      ST_SUB:  cmd_o.sub_en = 1'b1;
      ST_PIV:  cmd_o.sqrt_start = status_i.v_pos;
      ST_DIV:  cmd_o.div_start = 1'b1;
      ST_EMIT: begin
        cmd_o.slot = slot_q;
        cmd_o.emit = status_i.out_free;
      end
      ST_ERR:  cmd_o.err = status_i.out_free;
      ST_SQRT, ST_DIVW, ST_NEXT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_RECV;
      col_q    <= '0;
      slot_q   <= '0;
      row_q    <= '0;
      r_q      <= '0;
      d_q      <= '0;
      failed_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      slot_q   <= slot_d;
      row_q    <= row_d;
      r_q      <= r_d;
      d_q      <= d_d;
      failed_q <= failed_d;
    end
  end

  a_row_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RECV) |-> (row_q == '0))
    else $error("row offset nonzero outside receive");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q < n_w) && (slot_q < MB))
    else $error("column index out of range");

  a_failed_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> (state_q == ST_RECV || state_q == ST_NEXT))
    else $error("computation running on a failed matrix");

endmodule

[src/banded_cholesky_factor.sv]
// Top level of the banded Cholesky factor block.
// Usage:
//   elem_in    : one lower band element per transfer, column-major, diagonal
//                first; column j has min(band_lower, MAX_BAND, order-1-j)+1 elements.
//   factor_out : one element of L per transfer; column_last marks the end of a
//                column; not_pos_def flags a failed pivot (single result).
//   cfg        : write matrix_order (index 0) or band_lower (index 1) while
//                idle; any valid write restarts the current matrix.
// Timing: elements of a column are taken one per cycle while receiving. After the
//   last one the column is formed row by row: each window product passes through
//   read, multiply and accumulate steps, and each window column skipped as out of
//   band takes a single check; the sum is then subtracted, row 0 takes the root
//   and each subdiagonal row the divide, each followed by the emit; a final step
//   closes the column. The iterative divider sets the pace.
// Reset: the register file returns to order 1, band 0; no output is pending.
//   The factor window holds no data until written and needs no clearing.
// Stall: a result waits in the output register; the next result stalls until
//   it is taken, and no new element is accepted while a column is in progress.
`timescale 1ns / 1ps
module banded_cholesky_factor #(
  parameter int MAX_BAND   = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bcf_elem_if.sink                       elem_in,
  bcf_factor_if.source                   factor_out,
  input  logic                           cfg_we_i,
  input  logic [bcf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bcf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bcf_pkg::*;

  bcf_cmd_t    cmd;
  bcf_status_t status;
  logic        in_ready;

  // Sequencer: owns column/row bookkeeping and the configuration registers.
  bcf_ctrl #(
    .MAX_BAND (MAX_BAND)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (elem_in.valid),
    .in_ready_o  (in_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic: window memory, accumulate, root, divide and output register.
  bcf_dpath #(
    .MAX_BAND   (MAX_BAND),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (elem_in.element_value),
    .out_ready_i (factor_out.ready),
    .out_valid_o (factor_out.valid),
    .out_value_o (factor_out.factor_value),
    .out_last_o  (factor_out.column_last),
    .out_npd_o   (factor_out.not_pos_def)
  );

  assign elem_in.ready = in_ready;

endmodule
